/* rtl/text_console_writer_defines.svh */
// Assertion macros used by the console writer controller.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Property checked at every rising clock edge, off while reset is held.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
`default_nettype none
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);

    // field widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int RIDX_W   = 11;
    localparam int COLOR_W  = 8;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int OPOS_W   = 11;
    localparam int CELL_W   = 16;

    localparam int S_TDATA_W = ((CHAR_W + RIDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OCOL_W + OROW_W + OPOS_W + CELL_W + 7) / 8) * 8;

    // actions
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam int                TAB_STEP     = 4;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;
    localparam logic [CELL_W-1:0]  CELL_RESET  = 16'h0720;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic item_load;
        logic exec;
        logic cell_load;
        logic copy;
        logic blank;
        logic init_fill;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_read;
        logic need_scroll;
        logic copy_done;
        logic fill_last;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/tcw_ctrl.sv */
`default_nettype none
`include "text_console_writer_defines.svh"
module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  wire  m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sts.fill_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (sts.is_clear)         state_next = ST_BLANK;
                else if (sts.need_scroll) state_next = ST_SCROLL;
                else if (sts.is_read)     state_next = ST_READ;
                else                      state_next = ST_DONE;
            end
            ST_READ:   state_next = ST_DONE;
            ST_SCROLL: begin
                if (sts.copy_done) state_next = ST_BLANK;
            end
            ST_BLANK: begin
                if (sts.fill_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.blank     = 1'b1;
                cmd.init_fill = 1'b1;
            end
            ST_IDLE:   cmd.item_load = s_tvalid;
            ST_EXEC:   cmd.exec      = 1'b1;
            ST_READ:   cmd.cell_load = 1'b1;
            ST_SCROLL: cmd.copy      = 1'b1;
            ST_BLANK:  cmd.blank     = 1'b1;
            ST_DONE:   cmd.out_load  = !out_vld_reg || m_tready;
            default:   cmd = '0;
        endcase
    end

    assign out_vld_next = cmd.out_load || (out_vld_reg && !m_tready);
    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = out_vld_reg;

    `TCW_ASSERT(a_no_overwrite, aclk, aresetn, out_vld_reg && !m_tready |-> !cmd.out_load, "pending result overwritten")
    `TCW_ASSERT(a_init_quiet, aclk, aresetn, state_reg == ST_INIT |-> !s_tready && !out_vld_reg, "channel active during fill")
    `TCW_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_EXEC && !s_tready, "accepted word not executed")

endmodule
`default_nettype wire

/* rtl/tcw_dp.sv */
`default_nettype none
module tcw_dp
    import tcw_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_we,
    input  wire  [COLOR_W-1:0]   cfg_wdata,
    input  wire  [S_TDATA_W-1:0] s_tdata,
    input  wire  [ACTION_W-1:0]  s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COL_LIM   = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0]    TAB_MASK  = ~((COL_W + 1)'(TAB_STEP - 1));

    logic [CELL_W-1:0] mem [CELLS];

    logic [COLOR_W-1:0]  color_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                pend_vld_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic [CELL_W-1:0]   rdata_reg;
    logic [ACTION_W-1:0] act_reg;
    logic [CHAR_W-1:0]   chr_reg;
    logic [RIDX_W-1:0]   ridx_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [M_TDATA_W-1:0] tdata_reg;

    logic [ADDR_W-1:0] base;
    logic [COL_W:0]    col_inc, tab_col;
    logic              new_line, w_en;
    logic [ADDR_W-1:0] w_addr;
    logic [CHAR_W-1:0] w_chr;
    logic [COL_W-1:0]  exec_col;
    logic [ROW_W-1:0]  exec_row;
    logic              need_scroll;

    logic              rd_en, ridx_ok;
    logic [31:0]       ridx_ext;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic              mem_we;
    logic [CELL_W-1:0] mem_wdata;

    // cursor position as a linear cell index
    assign base    = ADDR_W'(row_reg) * COL_STEP + ADDR_W'(col_reg);
    assign col_inc = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign tab_col = ({1'b0, col_reg} + (COL_W + 1)'(TAB_STEP)) & TAB_MASK;

    always_comb begin
        exec_col    = col_reg;
        exec_row    = row_reg;
        new_line    = 1'b0;
        w_en        = 1'b0;
        w_addr      = base;
        w_chr       = chr_reg;
        need_scroll = 1'b0;
        case (act_reg)
            ACT_PUT: begin
                case (chr_reg)
                    CH_NEWLINE: new_line = 1'b1;
                    CH_RETURN:  exec_col = '0;
                    CH_TAB: begin
                        if (tab_col >= COL_LIM) new_line = 1'b1;
                        else exec_col = tab_col[COL_W-1:0];
                    end
                    CH_BACKSPACE: begin
                        // previous cell is base - 1 both mid row and at row start
                        if (col_reg != '0 || row_reg != '0) begin
                            w_en   = 1'b1;
                            w_addr = base - ADDR_W'(1);
                            w_chr  = CH_SPACE;
                            if (col_reg != '0) begin
                                exec_col = col_reg - COL_W'(1);
                            end else begin
                                exec_col = COL_LAST;
                                exec_row = row_reg - ROW_W'(1);
                            end
                        end
                    end
                    default: begin
                        w_en = 1'b1;
                        if (col_inc >= COL_LIM) new_line = 1'b1;
                        else exec_col = col_inc[COL_W-1:0];
                    end
                endcase
            end
            ACT_CLEAR: begin
                exec_col = '0;
                exec_row = '0;
            end
            default: ;
        endcase
        if (new_line) begin
            exec_col = '0;
            if (row_reg == ROW_LAST) need_scroll = 1'b1;
            else exec_row = row_reg + ROW_W'(1);
        end
    end

    assign sts.need_scroll = need_scroll;
    assign sts.is_clear    = (act_reg == ACT_CLEAR);
    assign sts.is_read     = (act_reg == ACT_READ);
    assign sts.copy_done   = (cnt_reg == COPY_END) && !pend_vld_reg;
    assign sts.fill_last   = (cnt_reg == CELL_LAST);

    // scroll copy: read cell i + COLUMNS now, write it to cell i next cycle
    assign rd_en     = cmd.copy && (cnt_reg < COPY_END);
    assign ridx_ext  = 32'(ridx_reg);
    assign ridx_ok   = ridx_ext < 32'(CELLS);
    assign mem_raddr = cmd.copy ? (cnt_reg + COL_STEP) : ridx_ext[ADDR_W-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = {color_reg, CH_SPACE};
        if (cmd.exec && w_en) begin
            mem_we    = 1'b1;
            mem_waddr = w_addr;
            mem_wdata = {color_reg, w_chr};
        end else if (pend_vld_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = rdata_reg;
        end else if (cmd.blank) begin
            mem_we    = 1'b1;
            mem_wdata = cmd.init_fill ? CELL_RESET : {color_reg, CH_SPACE};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.exec) begin
            col_next = exec_col;
            row_next = exec_row;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.exec)                  cnt_next = '0;
        else if (rd_en || cmd.blank)   cnt_next = cnt_reg + ADDR_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg    <= COLOR_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) color_reg <= cfg_wdata;
            col_reg      <= col_next;
            row_reg      <= row_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= cnt_reg;
        if (cmd.item_load) begin
            act_reg  <= s_tuser;
            chr_reg  <= s_tdata[CHAR_W-1:0];
            ridx_reg <= s_tdata[CHAR_W +: RIDX_W];
        end
        if (cmd.exec)      cell_reg <= '0;
        if (cmd.cell_load) cell_reg <= ridx_ok ? rdata_reg : '0;
        if (cmd.out_load) begin
            tdata_reg <= M_TDATA_W'({cell_reg, OPOS_W'(base), OROW_W'(row_reg),
                                     OCOL_W'(col_reg)});
        end
    end

    assign m_tdata = tdata_reg;

endmodule
`default_nettype wire

/* rtl/text_console_writer.sv */
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor.
// Input stream s_axis: tuser carries the action (put, clear, read), tdata the
// character and the read index. One word in gives exactly one result word on
// m_axis with the cursor column, row, linear position and, for a read, the cell.
// cfg_we/cfg_wdata load the text color; users must do so while idle (unenforced).
// Steps per word: a plain put, return, tab, backspace or idle code passes
// through accept, execute and load result, and a read adds a cell read
// before the load; the result is registered in the load step, and the
// controller then returns to idle to accept the next word.
// A scroll adds a copy sweep, the last write-back and then a blank of the
// bottom row, and a clear adds a blank sweep of the whole screen; both are
// bound by the single write port of the screen RAM.
// After reset all CELLS cells (2000 at 80x25) of the screen RAM are swept to
// blank 0x0720 with s_axis_tready low; cursor homes and the color returns to 7.
// The result sits in an output register: if m_axis_tready is low the word is
// held, the next input is still taken and worked, and it then waits to load.
`default_nettype none
module text_console_writer
    import tcw_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    // text color register
    input  wire                  cfg_we,
    input  wire  [COLOR_W-1:0]   cfg_wdata,
    // input words
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [S_TDATA_W-1:0] s_axis_tdata,  // char_code[7:0], read_index[18:8]
    input  wire  [ACTION_W-1:0]  s_axis_tuser,  // action[1:0]
    // result words
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // cursor_column[6:0], cursor_row[11:7], cursor_position[22:12],
    // cell_value[38:23]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    cmd_t cmd;   // controller to datapath
    sts_t sts;   // datapath to controller

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // screen RAM, cursor, sweep counter and result register
    tcw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tdata   (m_axis_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire
